@@ design/rbmc_pkg.sv @@
package rbmc_pkg;

  localparam int MAX_LEVELS = 13;
  localparam int DIM_W      = 13;
  localparam int POS_W      = 12;
  localparam int LVL_W      = 4;
  localparam int LS_AW      = 12;
  localparam int SUM_W      = 10;
  localparam logic [DIM_W-1:0] MAX_DIM = 13'd4096;

  // Configuration register indexes.
  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_MIPS   = 2'd2;

  // Sequencer states.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LEV  = 2'd1;
  localparam logic [1:0] ST_RD   = 2'd2;

  typedef logic [3:0][7:0]       pix_t;
  typedef logic [3:0][SUM_W-1:0] sum_t;

endpackage

@@ design/rbmc_line_ram.sv @@
module rbmc_line_ram (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [rbmc_pkg::LS_AW-1:0] wr_addr,
  input  rbmc_pkg::sum_t             wr_data,
  input  logic                       rd_en,
  input  logic [rbmc_pkg::LS_AW-1:0] rd_addr,
  output rbmc_pkg::sum_t             rd_data
);

  rbmc_pkg::sum_t mem [(1 << rbmc_pkg::LS_AW)];

  // One write and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ design/rbmc_avg_unit.sv @@
module rbmc_avg_unit (
  input  rbmc_pkg::sum_t a,
  input  rbmc_pkg::sum_t b,
  output rbmc_pkg::pix_t avg
);

  // Rounded quarter of a two-term sum, per channel.
  always_comb begin
    logic [rbmc_pkg::SUM_W+1:0] t;
    for (int c = 0; c < 4; c++) begin
      t = {2'b00, a[c]} + {2'b00, b[c]} + 12'd2;
      avg[c] = t[9:2];
    end
  end

endmodule

@@ design/rgba8_box_filter_mip_chain.sv @@
// Streaming RGBA8 mip chain generator.
// Base pixels enter on the in_ channel in raster order, one word each, red in
// the lowest byte. Every pixel is echoed as a level 0 word on the out_ channel,
// and with mips enabled each lower level pixel follows as soon as its 2x2
// block is complete, so levels come out interleaved. out_tlast marks the last
// word caused by one input pixel, out_tuser marks the final pixel of the image.
// Width, height and mip enable are written on the cfg_ port while idle; any
// write to one of these three restarts the image at the top left of every level.
// One input pixel holds the sequencer in ST_LEV for each result word, plus a
// pass through ST_RD for each lower level whose value needs the line store
// read (odd rows). The next pixel is accepted only once the sequencer is back
// in idle, so a new pixel is not taken before the last one is through.
// A single shared averaging unit and one line store serve all levels.
// in_tready is high only while the sequencer is idle.
// The result register holds a word while out_tready is low and the sequencer
// waits for it to drain before producing the next one.
// Synchronous reset clears the sequencer, level cursors, output valid and
// cfg registers (width 1, height 1, mips off); the line store needs no clearing.
module rgba8_box_filter_mip_chain (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // red, green, blue, alpha
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // level, pos_x, pos_y, out_red, out_green,
                                  // out_blue, out_alpha, 4 zero bits
  output logic        out_tlast,  // last_of_run
  output logic        out_tuser   // chain_done
);

  localparam int NL = rbmc_pkg::MAX_LEVELS;
  localparam int DW = rbmc_pkg::DIM_W;
  localparam int PW = rbmc_pkg::POS_W;
  localparam int LW = rbmc_pkg::LVL_W;
  localparam int AW = rbmc_pkg::LS_AW;

  logic [DW-1:0] width_r, height_r;
  logic          mips_r;
  logic [1:0]    state_r, state_nxt;
  logic [LW-1:0] lv_r, lv_nxt;
  logic [DW-1:0] lw_r, lw_nxt, lh_r, lh_nxt;
  logic [AW-1:0] off_r, off_nxt;
  rbmc_pkg::pix_t pix_r, pix_nxt;
  rbmc_pkg::sum_t pair_r, pair_nxt;
  logic [PW-1:0] cur_x_r [NL];
  logic [PW-1:0] cur_y_r [NL];
  rbmc_pkg::pix_t hold_r [NL];
  logic          out_valid_r;
  logic [63:0]   out_data_r;
  logic          out_last_r, out_done_r;

  logic [DW-1:0] w0, h0, nw, nh;
  logic [PW-1:0] x, y;
  logic          has_next, hok, have, st_wr, st_rd, fire, last_lv;
  rbmc_pkg::sum_t pair, avg_a, avg_b;
  rbmc_pkg::pix_t avg;
  rbmc_pkg::sum_t rd_data;
  logic [AW-1:0] idx;

  function automatic logic [DW-1:0] clamp_dim(input logic [DW-1:0] v);
    if (v == '0) return DW'(1);
    if (v > rbmc_pkg::MAX_DIM) return rbmc_pkg::MAX_DIM;
    return v;
  endfunction

  function automatic logic [DW-1:0] half_dim(input logic [DW-1:0] v);
    return (v[DW-1:1] == '0) ? DW'(1) : {1'b0, v[DW-1:1]};
  endfunction

  assign w0 = clamp_dim(width_r);
  assign h0 = clamp_dim(height_r);
  assign nw = half_dim(lw_r);
  assign nh = half_dim(lh_r);
  assign in_tready = (state_r == rbmc_pkg::ST_IDLE);
  assign fire = (state_r == rbmc_pkg::ST_LEV) && (!out_valid_r || out_tready);

  // Per-level decode: position, pair forming and line store access.
  always_comb begin
    x = cur_x_r[lv_r];
    y = cur_y_r[lv_r];
    if ({1'b0, x} >= lw_r || {1'b0, y} >= lh_r) begin
      x = '0;
      y = '0;
    end
    has_next = mips_r && (lv_r != LW'(NL - 1)) && !(lw_r == DW'(1) && lh_r == DW'(1));
    last_lv = !has_next;
    hok = 1'b0;
    pair = '0;
    if (lw_r == DW'(1)) begin
      for (int c = 0; c < 4; c++) pair[c] = {1'b0, pix_r[c], 1'b0};
      hok = 1'b1;
    end else if ({2'b00, x} < {nw, 1'b0} && x[0]) begin
      for (int c = 0; c < 4; c++) pair[c] = {2'b00, hold_r[lv_r][c]} + {2'b00, pix_r[c]};
      hok = 1'b1;
    end
    hok = hok && has_next;
    have = 1'b0;
    st_wr = 1'b0;
    if (hok) begin
      if (lh_r == DW'(1)) begin
        have = 1'b1;
      end else if ({2'b00, y} < {nh, 1'b0}) begin
        have = y[0];
        st_wr = !y[0];
      end
    end
    st_rd = have && (lh_r != DW'(1));
    idx = off_r + AW'(x >> 1);
  end

  rbmc_line_ram u_ram (
    .clk     (clk),
    .wr_en   (fire && st_wr),
    .wr_addr (idx),
    .wr_data (pair),
    .rd_en   (fire && st_rd),
    .rd_addr (idx),
    .rd_data (rd_data)
  );

  // The averager serves both the single-row case and the line store case.
  assign avg_a = (state_r == rbmc_pkg::ST_RD) ? rd_data : pair;
  assign avg_b = (state_r == rbmc_pkg::ST_RD) ? pair_r : pair;

  rbmc_avg_unit u_avg (
    .a   (avg_a),
    .b   (avg_b),
    .avg (avg)
  );

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    lv_nxt = lv_r;
    lw_nxt = lw_r;
    lh_nxt = lh_r;
    off_nxt = off_r;
    pix_nxt = pix_r;
    pair_nxt = pair_r;
    unique case (state_r)
      rbmc_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = rbmc_pkg::ST_LEV;
          lv_nxt = '0;
          lw_nxt = w0;
          lh_nxt = h0;
          off_nxt = '0;
          pix_nxt = in_tdata;
        end
      end
      rbmc_pkg::ST_LEV: begin
        if (fire) begin
          if (st_rd) begin
            pair_nxt = pair;
            state_nxt = rbmc_pkg::ST_RD;
          end else if (have) begin
            pix_nxt = avg;
            lv_nxt = lv_r + LW'(1);
            lw_nxt = nw;
            lh_nxt = nh;
            off_nxt = off_r + nw[AW-1:0];
          end else begin
            state_nxt = rbmc_pkg::ST_IDLE;
          end
        end
      end
      rbmc_pkg::ST_RD: begin
        pix_nxt = avg;
        lv_nxt = lv_r + LW'(1);
        lw_nxt = nw;
        lh_nxt = nh;
        off_nxt = off_r + nw[AW-1:0];
        state_nxt = rbmc_pkg::ST_LEV;
      end
      default: state_nxt = rbmc_pkg::ST_IDLE;
    endcase
  end

  // Control registers, cursors and the result valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rbmc_pkg::ST_IDLE;
      width_r <= DW'(1);
      height_r <= DW'(1);
      mips_r <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NL; i++) begin
        cur_x_r[i] <= '0;
        cur_y_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      // A new word fills the result register; an accepted word empties it.
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr_en && (cfg_index == rbmc_pkg::CFG_WIDTH ||
                        cfg_index == rbmc_pkg::CFG_HEIGHT ||
                        cfg_index == rbmc_pkg::CFG_MIPS)) begin
        for (int i = 0; i < NL; i++) begin
          cur_x_r[i] <= '0;
          cur_y_r[i] <= '0;
        end
        unique case (cfg_index)
          rbmc_pkg::CFG_WIDTH:  width_r <= cfg_wdata;
          rbmc_pkg::CFG_HEIGHT: height_r <= cfg_wdata;
          rbmc_pkg::CFG_MIPS:   mips_r <= cfg_wdata[0];
          default: ;
        endcase
      end else if (fire) begin
        if ({1'b0, x} + DW'(1) < lw_r) begin
          cur_x_r[lv_r] <= x + PW'(1);
          cur_y_r[lv_r] <= y;
        end else begin
          cur_x_r[lv_r] <= '0;
          cur_y_r[lv_r] <= ({1'b0, y} + DW'(1) < lh_r) ? y + PW'(1) : '0;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    lv_r <= lv_nxt;
    lw_r <= lw_nxt;
    lh_r <= lh_nxt;
    off_r <= off_nxt;
    pix_r <= pix_nxt;
    pair_r <= pair_nxt;
    if (fire) begin
      if (has_next && lw_r != DW'(1) && !x[0]) begin
        hold_r[lv_r] <= pix_r;
      end
      out_data_r <= {4'b0000, pix_r, y, x, lv_r};
      out_last_r <= !have;
      out_done_r <= last_lv && ({1'b0, x} == lw_r - DW'(1)) && ({1'b0, y} == lh_r - DW'(1));
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_done_r;

endmodule

@@ design/rbmc_checker.sv @@
module rbmc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic        out_tlast,
  input logic        out_tuser
);

  // A stalled result word stays offered.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  // One pixel at a time: ready drops right after an accept.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while busy");

  // The final pixel of the image ends its run.
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("chain done without end of run");

endmodule

bind rgba8_box_filter_mip_chain rbmc_checker u_rbmc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

@@ tb/sv/rgba8_box_filter_mip_chain_tb.sv @@
`timescale 1ns / 1ps

module rgba8_box_filter_mip_chain_tb;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [1:0]  cfg_index;
  logic [12:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // red, green, blue, alpha
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;  // level, pos_x, pos_y, red, green, blue, alpha, 4 zero bits
  logic        out_tlast;  // last_of_run
  logic        out_tuser;  // chain_done

  rgba8_box_filter_mip_chain uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser)
  );

  typedef struct packed {
    logic [rbmc_pkg::LVL_W-1:0] lvl;
    logic [rbmc_pkg::POS_W-1:0] px;
    logic [rbmc_pkg::POS_W-1:0] py;
    rbmc_pkg::pix_t             rgba;
    logic                       last_run;
    logic                       done;
  } mip_word_t;

  // Tracks the mip chain state and holds the words the block owes us.
  class mip_scoreboard;
    int unsigned img_w, img_h, mips_on;
    int unsigned cur_x[rbmc_pkg::MAX_LEVELS], cur_y[rbmc_pkg::MAX_LEVELS];
    logic [7:0]  hold_pix[rbmc_pkg::MAX_LEVELS][4];
    logic [9:0]  line_sums[4096][4];
    mip_word_t   owed[$];
    int          errors;
    int          n_in;

    function new();
      img_w = 1; img_h = 1; mips_on = 0; errors = 0; n_in = 0;
      restart();
    endfunction

    function void restart();
      for (int i = 0; i < rbmc_pkg::MAX_LEVELS; i++) begin
        cur_x[i] = 0; cur_y[i] = 0;
      end
    endfunction

    function int unsigned dim_eff(int unsigned v);
      if (v == 0) return 1;
      if (v > 4096) return 4096;
      return v;
    endfunction

    function void write_reg(logic [1:0] idx, logic [12:0] val);
      case (idx)
        rbmc_pkg::CFG_WIDTH:  img_w = int'(val);
        rbmc_pkg::CFG_HEIGHT: img_h = int'(val);
        rbmc_pkg::CFG_MIPS:   mips_on = int'(val[0]);
        default: return;
      endcase
      restart();
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    // Works out every word one base pixel causes, level 0 first.
    function void note_pixel(rbmc_pkg::pix_t p);
      int unsigned w[rbmc_pkg::MAX_LEVELS], h[rbmc_pkg::MAX_LEVELS];
      int unsigned off[rbmc_pkg::MAX_LEVELS];
      int unsigned nlev, lv, x, y, lw, lh, nw, nh, idx;
      int unsigned pix[4], pair[4], total[4];
      bit have, hok;
      mip_word_t e;
      mip_word_t run[$];
      n_in++;
      w[0] = dim_eff(img_w); h[0] = dim_eff(img_h); off[0] = 0;
      nlev = 1; lv = 0;
      if (mips_on != 0) begin
        while (nlev < rbmc_pkg::MAX_LEVELS && !(w[nlev-1] == 1 && h[nlev-1] == 1)) begin
          w[nlev] = (w[nlev-1] >> 1) ? (w[nlev-1] >> 1) : 1;
          h[nlev] = (h[nlev-1] >> 1) ? (h[nlev-1] >> 1) : 1;
          off[nlev] = off[nlev-1] + w[nlev];
          nlev++;
        end
      end
      for (int c = 0; c < 4; c++) pix[c] = int'(p[c]);
      have = 1;
      while (have) begin
        x = cur_x[lv]; y = cur_y[lv]; lw = w[lv]; lh = h[lv]; hok = 0;
        if (x >= lw || y >= lh) begin
          x = 0; y = 0;
        end
        e.lvl = 4'(lv); e.px = 12'(x); e.py = 12'(y);
        for (int c = 0; c < 4; c++) e.rgba[c] = 8'(pix[c]);
        e.last_run = 0;
        e.done = (lv == nlev - 1 && x == lw - 1 && y == lh - 1);
        run.insert(run.size(), e);
        if (x + 1 < lw) begin
          cur_x[lv] = x + 1; cur_y[lv] = y;
        end else begin
          cur_x[lv] = 0; cur_y[lv] = (y + 1 < lh) ? y + 1 : 0;
        end
        have = 0;
        if (lv + 1 < nlev) begin
          nw = w[lv+1]; nh = h[lv+1];
          // Horizontal pair: a one-wide level pairs the pixel with itself.
          if (lw == 1) begin
            for (int c = 0; c < 4; c++) pair[c] = 2 * pix[c];
            hok = 1;
          end else if (x < 2 * nw) begin
            if (x[0] == 0) begin
              for (int c = 0; c < 4; c++) hold_pix[lv][c] = 8'(pix[c]);
            end else begin
              for (int c = 0; c < 4; c++) pair[c] = hold_pix[lv][c] + pix[c];
              hok = 1;
            end
          end
          // Vertical pair through the line store, or doubled for one-high levels.
          if (hok) begin
            if (lh == 1) begin
              for (int c = 0; c < 4; c++) total[c] = 2 * pair[c];
              have = 1;
            end else if (y < 2 * nh) begin
              idx = (off[lv] + (x >> 1)) % 4096;
              if (y[0] == 0) begin
                for (int c = 0; c < 4; c++) line_sums[idx][c] = 10'(pair[c]);
              end else begin
                for (int c = 0; c < 4; c++) total[c] = line_sums[idx][c] + pair[c];
                have = 1;
              end
            end
          end
          if (have) begin
            for (int c = 0; c < 4; c++) pix[c] = ((total[c] + 2) >> 2) & 8'hFF;
            lv++;
          end
        end
      end
      run[run.size()-1].last_run = 1;
      foreach (run[i]) owed.insert(owed.size(), run[i]);
    endfunction

    task check_word(logic [63:0] d, logic tl, logic tu);
      mip_word_t e;
      if (owed.size() == 0) begin
        report_mismatch($sformatf("unexpected word %h", d));
        return;
      end
      e = owed.pop_front();
      if (d[3:0] !== e.lvl)
        report_mismatch($sformatf("level got %0d want %0d", d[3:0], e.lvl));
      if (d[15:4] !== e.px)
        report_mismatch($sformatf("pos_x got %0d want %0d", d[15:4], e.px));
      if (d[27:16] !== e.py)
        report_mismatch($sformatf("pos_y got %0d want %0d", d[27:16], e.py));
      if (d[59:28] !== e.rgba)
        report_mismatch($sformatf("rgba got %h want %h (lvl %0d x %0d y %0d)",
                                  d[59:28], e.rgba, e.lvl, e.px, e.py));
      if (d[63:60] !== 4'd0)
        report_mismatch($sformatf("pad bits got %h", d[63:60]));
      if (tl !== e.last_run)
        report_mismatch($sformatf("tlast got %b want %b", tl, e.last_run));
      if (tu !== e.done)
        report_mismatch($sformatf("tuser got %b want %b", tu, e.done));
    endtask
  endclass

  mip_scoreboard sb;
  int send_idle_pct;
  int recv_idle_pct;
  bit last_leg;
  bit stall_done = 1'b0;
  int stall_left = 0;

  // Free-running clock, 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver: checks accepted words and throttles out_tready, with one long hold-off.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_word(out_tdata, out_tlast, out_tuser);
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (!stall_done && sb.n_in >= 150) begin
      stall_done <= 1'b1;
      stall_left <= 400;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task wait_drained();
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task write_cfg(logic [1:0] idx, logic [12:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  // Starts a phase: idle block, new settings, new idling mode.
  task set_image(int unsigned w, int unsigned h, int unsigned m);
    wait_drained();
    if (last_leg) begin
      send_idle_pct = 0; recv_idle_pct = 0;
    end else if (sb.n_in < 90) begin
      send_idle_pct = 28; recv_idle_pct = 65;
    end else begin
      send_idle_pct = 65; recv_idle_pct = 28;
    end
    write_cfg(rbmc_pkg::CFG_WIDTH, 13'(w));
    write_cfg(rbmc_pkg::CFG_HEIGHT, 13'(h));
    write_cfg(rbmc_pkg::CFG_MIPS, 13'(m));
  endtask

  task send_pixel(logic [31:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_pixel(d);
  endtask

  task send_random(int n);
    for (int i = 0; i < n; i++) send_pixel($urandom());
  endtask

  task end_burst();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int unsigned w, h, cnt;
    sb = new();
    rst_n = 1'b0; cfg_wr_en = 1'b0; cfg_index = rbmc_pkg::CFG_WIDTH; cfg_wdata = '0;
    in_tvalid = 1'b0; in_tdata = '0;
    send_idle_pct = 28; recv_idle_pct = 65; last_leg = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: 1x1, no mips.
    send_pixel(32'h0000_0000); send_pixel(32'hFFFF_FFFF); end_burst();
    // Zero dimensions act as one; 1x1 with mips is a single level.
    set_image(0, 0, 1);
    send_pixel(32'hFFFF_FFFF); send_pixel(32'h0000_0000); end_burst();
    // Full-scale averaging, then rounding of 1+0+0+0 and 2+0+0+0.
    set_image(2, 2, 1);
    repeat (4) send_pixel(32'hFFFF_FFFF);
    send_pixel(32'h0202_0101); send_pixel(0); send_pixel(0); send_pixel(0);
    end_burst();
    // Odd sizes drop the last row and column; wraps into the next image.
    set_image(3, 5, 1);
    send_random(17); end_burst();
    // Oversized width and height clamp, mips off.
    set_image(13'h1FFF, 13'h1FFF, 0);
    send_random(3); end_burst();

    // Random phases: mostly whole small images, some cut short or run over.
    while (sb.n_in < 160) begin
      w = ($urandom_range(9) == 0) ? $urandom_range(20) : $urandom_range(9, 1);
      h = ($urandom_range(9) == 0) ? $urandom_range(20) : $urandom_range(9, 1);
      cnt = sb.dim_eff(w) * sb.dim_eff(h);
      case ($urandom_range(9))
        0: cnt = $urandom_range(cnt, 1);
        1: cnt = cnt + $urandom_range(cnt, 1);
        default: ;
      endcase
      if (cnt > 48) cnt = 48;
      set_image(w, h, ($urandom_range(7) != 0));
      send_random(cnt);
      end_burst();
    end

    // Extremes, each cut short: a deep chain on a full-width row, a tall
    // column and a clamped width.
    last_leg = 1'b1;
    set_image(4096, 1, 1);
    send_random(48); end_burst();
    set_image(1, 4096, 1);
    send_random(24); end_burst();
    set_image(13'h1FFF, 2, 1);
    send_random(32); end_burst();

    while (sb.owed.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
